@@ hw/rtl/cbwm_pkg.sv @@
// Shared types and constants for the CPU bank window mapper.
// Used by cbwm_regs, cbwm_xlate and cpu_bank_window_mapper; no dependencies.
package cbwm_pkg;

    typedef enum logic [2:0] {
        TGT_NONE   = 3'd0,
        TGT_ROM    = 3'd1,
        TGT_WORK   = 3'd2,
        TGT_BACKUP = 3'd3,
        TGT_REG    = 3'd4
    } target_t;

    typedef enum logic [1:0] {
        MODE_32K   = 2'd0,
        MODE_16K   = 2'd1,
        MODE_MIXED = 2'd2,
        MODE_8K    = 2'd3
    } mode_t;

    localparam logic [15:0] ADDR_MODE    = 16'h5100;
    localparam logic [15:0] ADDR_KEY_ONE = 16'h5102;
    localparam logic [15:0] ADDR_KEY_TWO = 16'h5103;
    localparam logic [15:0] ADDR_BANK0   = 16'h5113;
    localparam logic [15:0] ADDR_BANK1   = 16'h5114;
    localparam logic [15:0] ADDR_BANK2   = 16'h5115;
    localparam logic [15:0] ADDR_BANK3   = 16'h5116;
    localparam logic [15:0] ADDR_BANK4   = 16'h5117;
    localparam logic [15:0] ADDR_MCAND   = 16'h5205;
    localparam logic [15:0] ADDR_MPLIER  = 16'h5206;
    localparam logic [15:0] ADDR_WINDOWS = 16'h6000;

    localparam logic [1:0] KEY_ONE_CODE = 2'd2;
    localparam logic [1:0] KEY_TWO_CODE = 2'd1;

    localparam logic [7:0] MASK_32K = 8'h7C;
    localparam logic [7:0] MASK_16K = 8'h7E;
    localparam logic [7:0] MASK_8K  = 8'h7F;
    localparam logic [7:0] ROM_BIT  = 8'h80;
    localparam logic [12:0] PAGE_OFFSET_MASK = 13'h1FFF;

    localparam int NUM_BANKS = 5;

    typedef struct packed {
        mode_t                          mode;
        logic [NUM_BANKS-1:0][7:0]      bank;
        logic                           key_one_ok;
        logic                           key_two_ok;
        logic [7:0]                     mcand;
        logic [7:0]                     mplier;
    } state_t;

    typedef struct packed {
        target_t     target;
        logic [19:0] memory_address;
        logic        write_enable;
        logic [7:0]  register_data;
    } result_t;

endpackage

@@ hw/rtl/cpu_bank_window_mapper.sv @@
// CPU bank window mapper: one bus word in, one translated word out.
// Uses cbwm_pkg, cbwm_regs and cbwm_xlate.
//
// Input channel (s_*): one CPU bus access per word: command (0 read,
// 1 write), 16-bit address and write byte. Writes below 0x6000 hit the
// mapper registers; accesses at 0x6000-0xFFFF are mapped through five
// 8 KB windows into ROM, work RAM or backup RAM.
// Output channel (m_*): one word per access with target, memory byte
// address, RAM write enable and multiplier product byte.
// m_valid rises in the cycle after input accept. Throughput is one word
// per cycle unless m_ready stalls; translation is a single combinational
// pass from the register file and the input port into the output register.
// A register write takes effect for the very next accepted word.
// Reset puts the mapper in five 8K windows, bank 0 = 0, others 0xFF,
// protect keys cleared, operands 0, and empties the output register;
// s_ready is held low while aresetn is asserted.
// When the receiver stalls, the output word holds and s_ready stays high
// only while the output register is free or being drained that cycle.
module cpu_bank_window_mapper #(
    parameter int ROM_BYTES        = 1048576,
    parameter int WORK_RAM_BYTES   = 32768,
    parameter int BACKUP_RAM_BYTES = 32768
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [15:0] s_bus_address,
    input  logic [7:0]  s_write_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_target,
    output logic [19:0] m_memory_address,
    output logic        m_memory_write_enable,
    output logic [7:0]  m_register_data
);

    logic               accept;
    cbwm_pkg::state_t   state;
    cbwm_pkg::result_t  result;
    cbwm_pkg::result_t  out_reg;
    logic               m_valid_reg;
    logic               m_valid_next;

    assign s_ready = aresetn && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    cbwm_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (accept && s_command),
        .wr_address (s_bus_address),
        .wr_data    (s_write_data),
        .state      (state)
    );

    cbwm_xlate #(
        .ROM_BYTES        (ROM_BYTES),
        .WORK_RAM_BYTES   (WORK_RAM_BYTES),
        .BACKUP_RAM_BYTES (BACKUP_RAM_BYTES)
    ) u_xlate (
        .state       (state),
        .command     (s_command),
        .bus_address (s_bus_address),
        .result      (result)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= result;
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_target              = out_reg.target;
    assign m_memory_address      = out_reg.memory_address;
    assign m_memory_write_enable = out_reg.write_enable;
    assign m_register_data       = out_reg.register_data;

    // write enable only ever goes out with a RAM target
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_memory_write_enable) |->
            (m_target == cbwm_pkg::TGT_WORK || m_target == cbwm_pkg::TGT_BACKUP))
        else $error("write enable without RAM target");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_target == cbwm_pkg::TGT_NONE || m_target == cbwm_pkg::TGT_REG)) |->
            (m_memory_address == 20'd0 && !m_memory_write_enable))
        else $error("memory fields set on non-memory word");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_register_data != 8'd0) |-> (m_target == cbwm_pkg::TGT_REG))
        else $error("register data outside product read");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_command && s_bus_address == cbwm_pkg::ADDR_MODE) |=>
            (state.mode == cbwm_pkg::mode_t'($past(s_write_data[1:0]))))
        else $error("mode write not applied");

    // bank 4 is ROM from reset on
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> state.bank[4][7])
        else $error("bank 4 lost its ROM bit");

endmodule

@@ hw/rtl/cbwm_regs.sv @@
// Mapper register file: mode, protect keys, bank selects, multiplier operands.
// Depends on cbwm_pkg.
module cbwm_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [15:0]       wr_address,
    input  logic [7:0]        wr_data,
    output cbwm_pkg::state_t  state
);

    cbwm_pkg::state_t state_reg;
    cbwm_pkg::state_t state_next;

    always_comb begin
        state_next = state_reg;
        if (wr_en) begin
            case (wr_address)
                cbwm_pkg::ADDR_MODE:    state_next.mode = cbwm_pkg::mode_t'(wr_data[1:0]);
                cbwm_pkg::ADDR_KEY_ONE:
                    state_next.key_one_ok = (wr_data[1:0] == cbwm_pkg::KEY_ONE_CODE);
                cbwm_pkg::ADDR_KEY_TWO:
                    state_next.key_two_ok = (wr_data[1:0] == cbwm_pkg::KEY_TWO_CODE);
                // bank 0 is always RAM, bank 4 always ROM
                cbwm_pkg::ADDR_BANK0:   state_next.bank[0] = wr_data & cbwm_pkg::MASK_8K;
                cbwm_pkg::ADDR_BANK1:   state_next.bank[1] = wr_data;
                cbwm_pkg::ADDR_BANK2:   state_next.bank[2] = wr_data;
                cbwm_pkg::ADDR_BANK3:   state_next.bank[3] = wr_data;
                cbwm_pkg::ADDR_BANK4:   state_next.bank[4] = wr_data | cbwm_pkg::ROM_BIT;
                cbwm_pkg::ADDR_MCAND:   state_next.mcand = wr_data;
                cbwm_pkg::ADDR_MPLIER:  state_next.mplier = wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode       <= cbwm_pkg::MODE_8K;
            state_reg.bank[0]    <= 8'h00;
            state_reg.bank[1]    <= 8'hFF;
            state_reg.bank[2]    <= 8'hFF;
            state_reg.bank[3]    <= 8'hFF;
            state_reg.bank[4]    <= 8'hFF;
            state_reg.key_one_ok <= 1'b0;
            state_reg.key_two_ok <= 1'b0;
            state_reg.mcand      <= 8'h00;
            state_reg.mplier     <= 8'h00;
        end else begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

@@ hw/rtl/cbwm_xlate.sv @@
// Address translation for one bus word: window select, bank fold, product read.
// Depends on cbwm_pkg.
module cbwm_xlate #(
    parameter int ROM_BYTES        = 1048576,
    parameter int WORK_RAM_BYTES   = 32768,
    parameter int BACKUP_RAM_BYTES = 32768
) (
    input  cbwm_pkg::state_t   state,
    input  logic               command,
    input  logic [15:0]        bus_address,
    output cbwm_pkg::result_t  result
);

    localparam logic [19:0] ROM_LIM    = 20'(ROM_BYTES - 1);
    localparam logic [19:0] WORK_LIM   = 20'(WORK_RAM_BYTES - 1);
    localparam logic [19:0] BACKUP_LIM = 20'(BACKUP_RAM_BYTES - 1);
    localparam logic WORK_PRESENT   = (WORK_RAM_BYTES != 0);
    localparam logic BACKUP_PRESENT = (BACKUP_RAM_BYTES != 0);

    function automatic logic [19:0] fold(input logic [7:0] page, input logic [12:0] offset,
                                         input logic [19:0] lim);
        logic [19:0] pmask;
        logic [19:0] base;
        pmask = lim & ~20'(cbwm_pkg::PAGE_OFFSET_MASK);
        base  = 20'({page, 13'd0});
        return (base & pmask) + (20'(offset) & lim);
    endfunction

    logic [2:0]  win;
    logic [2:0]  bank_idx;
    logic [7:0]  mask;
    logic [1:0]  sub;
    logic [7:0]  b;
    logic [7:0]  page;
    logic [12:0] offset;
    logic [15:0] product;

    assign win    = bus_address[15:13] - 3'd3;
    assign offset = bus_address[12:0];

    always_comb begin
        bank_idx = win;
        mask     = cbwm_pkg::MASK_8K;
        sub      = 2'd0;
        if (win != 3'd0) begin
            case (state.mode)
                cbwm_pkg::MODE_32K: begin
                    bank_idx = 3'd4;
                    mask     = cbwm_pkg::MASK_32K;
                    sub      = 2'(win - 3'd1);
                end
                cbwm_pkg::MODE_16K: begin
                    mask = cbwm_pkg::MASK_16K;
                    if (win <= 3'd2) begin
                        bank_idx = 3'd2;
                        sub      = 2'(win - 3'd1);
                    end else begin
                        bank_idx = 3'd4;
                        sub      = 2'(win - 3'd3);
                    end
                end
                cbwm_pkg::MODE_MIXED: begin
                    if (win <= 3'd2) begin
                        bank_idx = 3'd2;
                        mask     = cbwm_pkg::MASK_16K;
                        sub      = 2'(win - 3'd1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        case (bank_idx)
            3'd0:    b = state.bank[0];
            3'd1:    b = state.bank[1];
            3'd2:    b = state.bank[2];
            3'd3:    b = state.bank[3];
            default: b = state.bank[4];
        endcase
    end

    assign page    = (b & mask) + 8'(sub);
    assign product = 16'(state.mcand) * 16'(state.mplier);

    always_comb begin
        result.target         = cbwm_pkg::TGT_NONE;
        result.memory_address = 20'd0;
        result.write_enable   = 1'b0;
        result.register_data  = 8'd0;
        if (bus_address >= cbwm_pkg::ADDR_WINDOWS) begin
            if (b[7]) begin
                result.target         = cbwm_pkg::TGT_ROM;
                result.memory_address = fold(page, offset, ROM_LIM);
            end else if (b[2]) begin
                if (WORK_PRESENT) begin
                    result.target         = cbwm_pkg::TGT_WORK;
                    result.memory_address = fold(page, offset, WORK_LIM);
                    result.write_enable   = command && state.key_one_ok && state.key_two_ok;
                end
            end else if (BACKUP_PRESENT) begin
                result.target         = cbwm_pkg::TGT_BACKUP;
                result.memory_address = fold(page, offset, BACKUP_LIM);
                result.write_enable   = command && state.key_one_ok && state.key_two_ok;
            end
        end else if (!command) begin
            if (bus_address == cbwm_pkg::ADDR_MCAND) begin
                result.target        = cbwm_pkg::TGT_REG;
                result.register_data = product[7:0];
            end else if (bus_address == cbwm_pkg::ADDR_MPLIER) begin
                result.target        = cbwm_pkg::TGT_REG;
                result.register_data = product[15:8];
            end
        end
    end

endmodule
